[hw/rtl/lmd_pkg.sv]
// shared types, register indexes and constant tables of the vibrato delay
`default_nettype none
package lmd_pkg;

	localparam int CfgIdxBits = 2;
	typedef logic [CfgIdxBits-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_PHASE_STEP  = 2'd0;
	localparam cfg_idx_t CFG_DEPTH_CENTS = 2'd1;
	localparam cfg_idx_t CFG_BASE_DELAY  = 2'd2;
	localparam cfg_idx_t CFG_WET_LEVEL   = 2'd3;

	localparam int CfgDataBits = 24;
	typedef logic [CfgDataBits-1:0] cfg_data_t;

	localparam logic [10:0] DEPTH_MAX = 11'd1200;
	localparam logic [15:0] MIX_ONE   = 16'd32768;

	// floor(v / 75) for v below 2^23 as (v * RECIP_75) >> 30
	localparam logic [23:0] RECIP_75 = 24'd14316558;

	typedef logic [17:0] exp2_t;
	localparam exp2_t EXP2_TAB [17] = '{
		18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
		18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
		18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
	};

	typedef struct packed {
		logic en;
		logic keep;
	} mac_ctl_t;

	// quarter wave sine magnitude in q15, evaluated at elaboration only
	function automatic logic [15:0] sine_mag(input int unsigned j, input int unsigned sh);
		longint unsigned one;
		longint unsigned x;
		longint unsigned th;
		longint unsigned t2;
		longint unsigned a;
		longint unsigned b;
		longint unsigned c;
		longint unsigned s;
		longint unsigned v;
		one = 64'd1 << 30;
		x = 64'(j) << sh;
		th = x * 64'd25736;
		t2 = (th * th) >> 30;
		a = one - t2 / 64'd42;
		b = one - ((t2 * a) >> 30) / 64'd20;
		c = one - ((t2 * b) >> 30) / 64'd6;
		s = (th * c) >> 30;
		v = (s + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

endpackage
`default_nettype wire

[hw/rtl/lmd_if.sv]
// stream interfaces for input and output stereo frames
`default_nettype none
interface lmd_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;
	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface lmd_out_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

[hw/rtl/lmd_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none
module lmd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/lmd_mac.sv]
// shared signed multiply accumulate unit
`default_nettype none
module lmd_mac #(
	parameter int AW = 25,
	parameter int BW = 25,
	parameter int ACCW = 52
) (
	input  wire logic                    clk,
	input  wire lmd_pkg::mac_ctl_t       ctl,
	input  wire logic signed [AW-1:0]    a,
	input  wire logic signed [BW-1:0]    b,
	input  wire logic signed [ACCW-1:0]  addend,
	output logic signed [ACCW-1:0]       acc_q
);
	import lmd_pkg::*;

	logic signed [ACCW-1:0] prod;
	logic signed [ACCW-1:0] base;

	assign prod = ACCW'(a * b);
	assign base = ctl.keep ? acc_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + prod + addend;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/lfo_modulated_delay_pitch_drift_unit.sv]
// top level: stereo vibrato, lfo modulated fractional delay with dry/wet mix
//
// in_ch carries one stereo frame (left_in, right_in); out_ch returns one mixed
// frame per input frame, in order. A transfer happens when valid and ready are
// both high. cfg_we/cfg_idx/cfg_data write phase_step, depth_cents, the
// center delay and wet_level; write them only while no frame is in flight.
// Between a frame's transfer and the offer of its result, all products go
// through a single shared multiply accumulate unit, stepped by a sequencer,
// and each delay line is read twice through its one ram port.
// in_ch.ready is high only while the sequencer waits for a frame, so no new
// frame is taken until the last one is through. The result sits in an output
// register; the next frame is taken while it waits, and that frame stalls in
// its last step until the receiver has taken the earlier result.
// Reset (arst_n low) clears the lfo phase, the write pointer and the fill
// flag and loads register defaults; delay line entries not yet written since
// reset read as zero through the fill tracking, so no clearing pass is run.
`default_nettype none
module lfo_modulated_delay_pitch_drift_unit #(
	parameter int DELAY_DEPTH = 4096,
	parameter int SAMPLE_BITS = 24,
	parameter int SINE_TABLE_SIZE = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	lmd_in_if.sink                  in_ch,
	lmd_out_if.source               out_ch,
	input  wire logic               cfg_we,
	input  wire lmd_pkg::cfg_idx_t  cfg_idx,
	input  wire lmd_pkg::cfg_data_t cfg_data
);
	import lmd_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int DB = $clog2(DELAY_DEPTH);
	localparam int DW = DB + 16;
	localparam int DELW = (DW > 30) ? DW : 30;
	localparam int LB = $clog2(SINE_TABLE_SIZE);
	localparam int QS = SINE_TABLE_SIZE / 4;
	localparam int AW = ((SB > 24) ? SB : 24) + 1;
	localparam int BW = 25;
	localparam int ACCW = AW + BW + 2;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_SIN  = 5'd1;
	localparam logic [4:0] ST_DEV  = 5'd2;
	localparam logic [4:0] ST_RCP  = 5'd3;
	localparam logic [4:0] ST_INT  = 5'd4;
	localparam logic [4:0] ST_SCL  = 5'd5;
	localparam logic [4:0] ST_DEL  = 5'd6;
	localparam logic [4:0] ST_RD0  = 5'd7;
	localparam logic [4:0] ST_RD1  = 5'd8;
	localparam logic [4:0] ST_CAP  = 5'd9;
	localparam logic [4:0] ST_L0   = 5'd10;
	localparam logic [4:0] ST_L1   = 5'd11;
	localparam logic [4:0] ST_L2   = 5'd12;
	localparam logic [4:0] ST_L3   = 5'd13;
	localparam logic [4:0] ST_R0   = 5'd14;
	localparam logic [4:0] ST_R1   = 5'd15;
	localparam logic [4:0] ST_R2   = 5'd16;
	localparam logic [4:0] ST_R3   = 5'd17;
	localparam logic [4:0] ST_FIN  = 5'd18;

	localparam logic [DELW-1:0] DEL_LO = DELW'(1) << 16;
	localparam logic [DELW-1:0] DEL_HI = DELW'(DELAY_DEPTH - 1) << 16;

	logic [4:0]  state_q;
	logic [31:0] phase_q;
	logic [23:0] step_q;
	logic [10:0] depth_q;
	logic [11:0] base_q;
	logic [15:0] wet_q;
	logic [DB-1:0] wp_q;
	logic          full_q;

	logic signed [SB-1:0] dry_l_q, dry_r_q;
	logic signed [15:0]   sin_q;
	logic                 pos_q;
	exp2_t                tk_q;
	logic                 n_q;
	logic [DW-1:0]        del_q;
	logic                 v0_q, v1_q;
	logic signed [SB-1:0] al_q, ar_q, bl_q, br_q;
	logic signed [SB-1:0] wetx_q;
	logic signed [SB-1:0] lo_q;
	logic signed [SB-1:0] ol_q, or_q;
	logic                 ov_q;

	logic in_xfer, out_xfer, fin_go;

	// sine lookup over a quarter wave
	logic [15:0]   sin_rom [QS+1];
	logic [LB-1:0] sidx;
	logic [LB-2:0] jj;
	logic signed [15:0] sin_val;

	for (genvar g = 0; g <= QS; g++) begin : g_sin
		assign sin_rom[g] = sine_mag(g, 18 - LB);
	end

	assign sidx = phase_q[31 -: LB];
	assign jj = sidx[LB-2] ? (LB-1)'(QS) - {1'b0, sidx[LB-3:0]} : {1'b0, sidx[LB-3:0]};
	assign sin_val = sidx[LB-1] ? -$signed(sin_rom[jj]) : $signed(sin_rom[jj]);

	// shared arithmetic
	mac_ctl_t               mctl;
	logic signed [AW-1:0]   ma;
	logic signed [BW-1:0]   mb;
	logic signed [ACCW-1:0] madd;
	logic signed [ACCW-1:0] acc_q;

	lmd_mac #(.AW(AW), .BW(BW), .ACCW(ACCW)) u_mac (
		.clk    (clk),
		.ctl    (mctl),
		.a      (ma),
		.b      (mb),
		.addend (madd),
		.acc_q  (acc_q)
	);

	logic [10:0] dcl;
	logic [15:0] mcl;
	logic [15:0] mcomp;
	logic [26:0] mag;
	logic [23:0] wdiv;
	logic [15:0] em;
	logic [16:0] uu;
	logic [3:0]  kk;
	exp2_t       ediff;
	exp2_t       pp;
	logic [29:0] draw;
	logic [DELW-1:0] dext;
	logic [DELW-1:0] dclamp;
	logic [DB-1:0]   i0, i1, raddr;
	logic [16:0]     frc;

	assign dcl = (depth_q > DEPTH_MAX) ? DEPTH_MAX : depth_q;
	assign mcl = (wet_q > MIX_ONE) ? MIX_ONE : wet_q;
	assign mcomp = MIX_ONE - mcl;
	assign mag = acc_q[ACCW-1] ? 27'(-acc_q) : acc_q[26:0];
	assign wdiv = 24'((28'(mag) + 28'd300) >> 3);
	assign em = acc_q[45:30];
	assign uu = pos_q ? 17'd65536 - 17'(em) : 17'd65536 + 17'(em);
	assign kk = uu[15:12];
	assign ediff = EXP2_TAB[5'(kk) + 5'd1] - EXP2_TAB[kk];
	assign pp = tk_q + 18'(acc_q[24:12]);
	assign draw = acc_q[29:0];
	assign dext = n_q ? DELW'(draw) : DELW'(draw >> 1);
	assign dclamp = (dext < DEL_LO) ? DEL_LO : ((dext > DEL_HI) ? DEL_HI : dext);
	assign i0 = wp_q - del_q[DW-1:16];
	assign i1 = i0 - DB'(1);
	assign raddr = (state_q == ST_RD0) ? i0 : i1;
	assign frc = 17'd65536 - 17'(del_q[15:0]);

	logic signed [ACCW-16:0] mixr;
	logic signed [SB-1:0]    satv;
	logic signed [SB-1:0]    wetv;

	assign mixr = acc_q[ACCW-1:15];
	assign wetv = acc_q[SB+15:16];
	always_comb begin
		if (mixr > $signed((ACCW-15)'((64'd1 << (SB - 1)) - 64'd1))) begin
			satv = {1'b0, {(SB-1){1'b1}}};
		end else if (mixr < -$signed((ACCW-15)'(64'd1 << (SB - 1)))) begin
			satv = {1'b1, {(SB-1){1'b0}}};
		end else begin
			satv = mixr[SB-1:0];
		end
	end

	always_comb begin
		mctl = '0;
		ma = '0;
		mb = '0;
		madd = '0;
		unique case (state_q)
			ST_DEV: begin
				mctl.en = 1'b1;
				ma = AW'(sin_q);
				mb = BW'($signed({1'b0, dcl}));
			end
			ST_RCP: begin
				mctl.en = 1'b1;
				ma = AW'($signed({1'b0, wdiv}));
				mb = BW'($signed({1'b0, RECIP_75}));
			end
			ST_INT: begin
				mctl.en = 1'b1;
				ma = AW'($signed({1'b0, ediff}));
				mb = BW'($signed({1'b0, uu[11:0]}));
				madd = ACCW'(2048);
			end
			ST_SCL: begin
				mctl.en = 1'b1;
				ma = AW'($signed({1'b0, pp}));
				mb = BW'($signed({1'b0, base_q}));
			end
			ST_L0, ST_R0: begin
				mctl.en = 1'b1;
				ma = AW'((state_q == ST_L0) ? al_q : ar_q);
				mb = BW'($signed({1'b0, frc}));
			end
			ST_L1, ST_R1: begin
				mctl.en = 1'b1;
				mctl.keep = 1'b1;
				ma = AW'((state_q == ST_L1) ? bl_q : br_q);
				mb = BW'($signed({1'b0, del_q[15:0]}));
				madd = ACCW'(32768);
			end
			ST_L2, ST_R2: begin
				mctl.en = 1'b1;
				ma = AW'((state_q == ST_L2) ? dry_l_q : dry_r_q);
				mb = BW'($signed({1'b0, mcomp}));
			end
			ST_L3, ST_R3: begin
				mctl.en = 1'b1;
				mctl.keep = 1'b1;
				ma = AW'(wetx_q);
				mb = BW'($signed({1'b0, mcl}));
				madd = ACCW'(16384);
			end
			default: begin
			end
		endcase
	end

	// delay lines
	logic [SB-1:0] rd_l, rd_r;

	lmd_ram #(.WIDTH(SB), .DEPTH(DELAY_DEPTH)) u_ram_l (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (wp_q),
		.wdata (in_ch.left_in),
		.raddr (raddr),
		.rdata (rd_l)
	);

	lmd_ram #(.WIDTH(SB), .DEPTH(DELAY_DEPTH)) u_ram_r (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (wp_q),
		.wdata (in_ch.right_in),
		.raddr (raddr),
		.rdata (rd_r)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;
	assign fin_go = (state_q == ST_FIN) && (!ov_q || out_ch.ready);
	assign out_ch.valid = ov_q;
	assign out_ch.left_out = ol_q;
	assign out_ch.right_out = or_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			depth_q <= '0;
			base_q <= 12'd960;
			wet_q <= MIX_ONE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PHASE_STEP:  step_q <= cfg_data[23:0];
				CFG_DEPTH_CENTS: depth_q <= cfg_data[10:0];
				CFG_BASE_DELAY:  base_q <= cfg_data[11:0];
				CFG_WET_LEVEL:   wet_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			wp_q <= '0;
			full_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (out_xfer && !fin_go) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_xfer) state_q <= ST_SIN;
				ST_SIN: begin
					phase_q <= phase_q + 32'(step_q);
					state_q <= ST_DEV;
				end
				ST_DEV: state_q <= ST_RCP;
				ST_RCP: state_q <= ST_INT;
				ST_INT: state_q <= ST_SCL;
				ST_SCL: state_q <= ST_DEL;
				ST_DEL: state_q <= ST_RD0;
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_CAP;
				ST_CAP: state_q <= ST_L0;
				ST_L0: state_q <= ST_L1;
				ST_L1: state_q <= ST_L2;
				ST_L2: state_q <= ST_L3;
				ST_L3: state_q <= ST_R0;
				ST_R0: state_q <= ST_R1;
				ST_R1: state_q <= ST_R2;
				ST_R2: state_q <= ST_R3;
				ST_R3: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						ov_q <= 1'b1;
						wp_q <= wp_q + DB'(1);
						if (wp_q == DB'(DELAY_DEPTH - 1)) begin
							full_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dry_l_q <= in_ch.left_in;
			dry_r_q <= in_ch.right_in;
		end
		if (state_q == ST_SIN) sin_q <= sin_val;
		if (state_q == ST_RCP) pos_q <= !acc_q[ACCW-1] && (acc_q != '0);
		if (state_q == ST_INT) begin
			tk_q <= EXP2_TAB[kk];
			n_q <= uu[16];
		end
		if (state_q == ST_DEL) del_q <= dclamp[DW-1:0];
		if (state_q == ST_RD0) v0_q <= full_q || (i0 <= wp_q);
		if (state_q == ST_RD1) begin
			v1_q <= full_q || (i1 <= wp_q);
			al_q <= v0_q ? $signed(rd_l) : '0;
			ar_q <= v0_q ? $signed(rd_r) : '0;
		end
		if (state_q == ST_CAP) begin
			bl_q <= v1_q ? $signed(rd_l) : '0;
			br_q <= v1_q ? $signed(rd_r) : '0;
		end
		if (state_q == ST_L2 || state_q == ST_R2) wetx_q <= wetv;
		if (state_q == ST_R0) lo_q <= satv;
		if (fin_go) begin
			ol_q <= lo_q;
			or_q <= satv;
		end
	end

	a_del_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD0 |-> (DELW'(del_q) >= DEL_LO && DELW'(del_q) <= DEL_HI))
		else $error("delay out of clamp range");

	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> wp_q == $past(wp_q) + DB'(1))
		else $error("write pointer did not advance");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) == ST_FIN)
		else $error("result offered outside final step");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ch.ready)
		else $error("frame taken while busy");

endmodule
`default_nettype wire

[tb/tb_lmd_bfm.sv]
// testbench interfaces are provided by the rtl; this file holds the sine table helper for the tb
`default_nettype none
package tb_lmd_pkg;
	// quarter wave sine magnitude in q15 from the 7th order series in q30
	function automatic longint unsigned quarter_sine(input longint unsigned x);
		longint unsigned one;
		longint unsigned th;
		longint unsigned t2;
		longint unsigned a;
		longint unsigned b;
		longint unsigned c;
		longint unsigned s;
		longint unsigned v;
		one = 64'd1 << 30;
		th = x * 64'd25736;
		t2 = (th * th) >> 30;
		a = one - t2 / 64'd42;
		b = one - ((t2 * a) >> 30) / 64'd20;
		c = one - ((t2 * b) >> 30) / 64'd6;
		s = (th * c) >> 30;
		v = (s + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v;
	endfunction
endpackage
`default_nettype wire

[tb/tb.sv]
// testbench for the stereo vibrato delay: queued driver, monitor and frame predictor
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lmd_pkg::*;
	import tb_lmd_pkg::*;

	localparam int Depth = 4096;
	localparam int NumRandom = 1450;

	typedef struct packed {
		logic signed [23:0] left;
		logic signed [23:0] right;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_idx = CFG_PHASE_STEP;
	cfg_data_t cfg_data = '0;

	lmd_in_if #(.SAMPLE_BITS(24)) in_ch ();
	lmd_out_if #(.SAMPLE_BITS(24)) out_ch ();

	lfo_modulated_delay_pitch_drift_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	frame_t pending_frames[$];
	frame_t expected_frames[$];
	int errors = 0;
	int sent = 0;
	int hold_cycles = 0;
	bit hold_req = 1'b0;

	// predictor state
	longint unsigned m_step, m_depth, m_base, m_wet;
	logic [31:0] m_phase;
	int m_wp;
	longint m_left[Depth];
	longint m_right[Depth];

	function automatic longint fshift(input longint v, input int sh);
		if (v >= 0) begin
			return v >>> sh;
		end
		return -((-v + (64'sd1 <<< sh) - 1) >>> sh);
	endfunction

	function automatic longint sat24(input longint v);
		if (v > 8388607) begin
			return 8388607;
		end
		if (v < -8388608) begin
			return -8388608;
		end
		return v;
	endfunction

	function automatic longint lfo_sine(input logic [31:0] ph);
		longint unsigned idx, q, r, x, v;
		idx = ph >> 22;
		q = (idx * 4) / 1024;
		r = idx * 4 - q * 1024;
		x = (r << 16) / 1024;
		if (q[0]) begin
			x = 65536 - x;
		end
		v = quarter_sine(x);
		return (q >= 2) ? -longint'(v) : longint'(v);
	endfunction

	function automatic longint unsigned delay_now();
		longint s, d, prod, em, e;
		longint unsigned mag, u, n, f, k, fr, p, del, t0, t1;
		s = lfo_sine(m_phase);
		d = (m_depth > 1200) ? 1200 : longint'(m_depth);
		prod = s * d;
		mag = (prod < 0) ? -prod : prod;
		em = (mag + 300) / 600;
		e = (prod > 0) ? -em : em;
		u = e + 65536;
		n = u >> 16;
		f = u & 16'hFFFF;
		k = f >> 12;
		fr = f & 4095;
		t0 = EXP2_TAB[k];
		t1 = EXP2_TAB[k+1];
		p = t0 + (((t1 - t0) * fr + 2048) >> 12);
		del = m_base * p;
		if (n == 0) begin
			del = del >> 1;
		end else if (n >= 2) begin
			del = del << 1;
		end
		if (del < (64'd1 << 16)) begin
			return 64'd1 << 16;
		end
		if (del > (64'd4095 << 16)) begin
			return 64'd4095 << 16;
		end
		return del;
	endfunction

	function automatic longint mix_channel(input bit is_right, input longint dry,
			input longint unsigned del);
		longint unsigned k, fr;
		int i0, i1;
		longint a, b, wet, m;
		k = del >> 16;
		fr = del & 16'hFFFF;
		i0 = (m_wp + 2 * Depth - int'(k)) % Depth;
		i1 = (m_wp + 2 * Depth - int'(k) - 1) % Depth;
		a = is_right ? m_right[i0] : m_left[i0];
		b = is_right ? m_right[i1] : m_left[i1];
		wet = fshift(a * longint'(65536 - fr) + b * longint'(fr) + 32768, 16);
		m = (m_wet > 32768) ? 32768 : longint'(m_wet);
		return sat24(fshift(dry * (32768 - m) + wet * m + 16384, 15));
	endfunction

	function automatic frame_t predict_frame(input frame_t fin);
		longint unsigned del;
		frame_t res;
		del = delay_now();
		m_left[m_wp] = longint'(fin.left);
		m_right[m_wp] = longint'(fin.right);
		res.left = 24'(mix_channel(1'b0, longint'(fin.left), del));
		res.right = 24'(mix_channel(1'b1, longint'(fin.right), del));
		m_wp = (m_wp + 1) % Depth;
		m_phase = m_phase + m_step[31:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("tb: mismatch %s got %0d want %0d", what, got, want);
		errors++;
	endtask

	// driver
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.left_in <= '0;
			in_ch.right_in <= '0;
			gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_frames.push_back(predict_frame({in_ch.left_in, in_ch.right_in}));
				sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap > 0) begin
					in_ch.valid <= 1'b0;
					gap <= gap - 1;
				end else if (pending_frames.size() > 0) begin
					frame_t fr;
					fr = pending_frames.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.left_in <= fr.left;
					in_ch.right_in <= fr.right;
					gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
						: $urandom_range(0, 2) * $urandom_range(0, 1);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_frames.size() == 0) begin
					report_mismatch("unexpected transfer", out_ch.left_out, 0);
				end else begin
					frame_t w;
					w = expected_frames.pop_front();
					if (out_ch.left_out !== w.left) begin
						report_mismatch("left_out", out_ch.left_out, w.left);
					end
					if (out_ch.right_out !== w.right) begin
						report_mismatch("right_out", out_ch.right_out, w.right);
					end
				end
			end
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else if (hold_req) begin
				out_ch.ready <= 1'b0;
				hold_cycles <= 600;
			end else if ($urandom_range(0, 30) == 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles <= $urandom_range(10, 80);
			end else begin
				out_ch.ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input longint unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[23:0];
		case (idx)
			CFG_PHASE_STEP: m_step = val & 24'hFFFFFF;
			CFG_DEPTH_CENTS: m_depth = val & 11'h7FF;
			CFG_BASE_DELAY: m_base = val & 12'hFFF;
			default: m_wet = val & 16'hFFFF;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_frames.size() > 0 || in_ch.valid || expected_frames.size() > 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($urandom_range(0, 255));
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++) begin
			pending_frames.push_back({rand_sample(), rand_sample()});
		end
	endtask

	task automatic set_all(input longint unsigned st, input longint unsigned dp,
			input longint unsigned bd, input longint unsigned wl);
		write_reg(CFG_PHASE_STEP, st);
		write_reg(CFG_DEPTH_CENTS, dp);
		write_reg(CFG_BASE_DELAY, bd);
		write_reg(CFG_WET_LEVEL, wl);
	endtask

	initial begin
		m_step = 0;
		m_depth = 0;
		m_base = 960;
		m_wet = 32768;
		m_phase = 0;
		m_wp = 0;
		for (int i = 0; i < Depth; i++) begin
			m_left[i] = 0;
			m_right[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// directed: extremes, tiny and zero delay, over-range depth and mix
		set_all(24'hFFFFFF, 1200, 1, 32768);
		pending_frames.push_back({24'h7FFFFF, 24'h800000});
		pending_frames.push_back({24'h800000, 24'h7FFFFF});
		pending_frames.push_back({24'h000000, 24'hFFFFFF});
		pending_frames.push_back({24'h7FFFFF, 24'h7FFFFF});
		drain();
		set_all(24'h123456, 2047, 0, 65535);
		pending_frames.push_back({24'h800000, 24'h800000});
		pending_frames.push_back({24'h7FFFFF, 24'h000001});
		pending_frames.push_back({24'h555555, 24'hAAAAAA});
		drain();
		set_all(0, 0, 4095, 0);
		push_random(8);
		drain();
		set_all(24'h800000, 600, 2, 16384);
		push_random(8);
		drain();
		// random phases, one with a long receiver hold-off
		for (int ph = 0; ph < 6; ph++) begin
			set_all($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 20),
				$urandom_range(0, 2047), $urandom_range(0, 4095),
				$urandom_range(0, 65535));
			if (ph == 2) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			push_random(NumRandom / 6);
			drain();
		end
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
